@@ src/ffpd_pkg.sv @@
// ----------------------------------------------------------------------------
// ffpd_pkg
// Types and constants shared by the form field percent decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpd_pkg;

	// characters the parser reacts to
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_EQ      = 8'h3D;

	// longest key the matcher compares
	localparam logic [3:0] MAX_KEY_LENGTH = 4'd8;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_TEXT         = 2'd0;
	localparam logic [1:0] REG_KEY_LENGTH       = 2'd1;
	localparam logic [1:0] REG_MAX_VALUE_LENGTH = 2'd2;

	typedef struct packed {
		logic [63:0] key_text;
		logic [3:0]  key_len;
		logic [7:0]  max_value_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_last;
	} body_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       status_valid;
		logic       status_ok;
		logic       run_last;
	} result_t;

	// one result before run_last is known
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       status_valid;
		logic       status_ok;
	} entry_t;

	// all results caused by one input word
	typedef struct packed {
		logic [1:0]       count;
		entry_t [2:0]     entry;
	} bundle_t;

endpackage

`default_nettype wire

@@ src/ffpd_front.sv @@
// ----------------------------------------------------------------------------
// ffpd_front
// Body parser: matches the key, decodes the value and bundles the results
// of each accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire ffpd_pkg::body_t   body,
	input  wire ffpd_pkg::cfg_t    cfg,
	output logic                   bundle_push,
	output ffpd_pkg::bundle_t      bundle
);
	import ffpd_pkg::*;

	typedef enum logic [3:0] {
		PH_MATCH = 4'b0001,
		PH_SKIP  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	localparam logic [1:0] ESC_NONE    = 2'd0;
	localparam logic [1:0] ESC_PERCENT = 2'd1;
	localparam logic [1:0] ESC_ONE     = 2'd2;

	phase_t      phase_q, phase_d;
	logic [3:0]  kpos_q, kpos_d;
	logic [1:0]  esc_q, esc_d;
	logic [7:0]  pend_q, pend_d;
	logic [7:0]  cnt_q, cnt_d;
	logic        found_q, found_d;
	logic        ok_q, ok_d;
	logic        ended_q, ended_d;
	logic [1:0]  n;
	entry_t [2:0] res;

	// {is hex, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic entry_t byte_entry(input logic [7:0] b);
		entry_t e;
		e = '0;
		e.out_byte = b;
		e.byte_valid = 1'b1;
		return e;
	endfunction

	always_comb begin
		logic [3:0] kl;
		logic [7:0] kc;
		logic [7:0] b;
		logic [4:0] hi_h;
		logic [4:0] lo_h;
		entry_t     st;
		phase_d = phase_q;
		kpos_d  = kpos_q;
		esc_d   = esc_q;
		pend_d  = pend_q;
		cnt_d   = cnt_q;
		found_d = found_q;
		ok_d    = ok_q;
		ended_d = ended_q;
		n       = 2'd0;
		res     = '0;
		b       = body.body_byte;
		kl      = (cfg.key_len > MAX_KEY_LENGTH) ? MAX_KEY_LENGTH : cfg.key_len;
		kc      = cfg.key_text[{kpos_q[2:0], 3'b000} +: 8];
		hi_h    = hex_val(pend_q);
		lo_h    = hex_val(b);
		st      = '0;
		if (accept) begin
			if (!ended_q) begin
				if (b == CH_NUL) begin
					ended_d = 1'b1;
				end else if (b != CH_AMP) begin
					case (phase_q)
						PH_MATCH: begin
							if (kpos_q < kl) begin
								if (b == kc) begin
									kpos_d = kpos_q + 4'd1;
								end else begin
									phase_d = PH_SKIP;
								end
							end else if (b == CH_EQ) begin
								found_d = 1'b1;
								phase_d = PH_VALUE;
								cnt_d   = 8'd0;
								esc_d   = ESC_NONE;
							end else begin
								phase_d = PH_SKIP;
							end
						end
						PH_VALUE: begin
							case (esc_q)
								ESC_NONE: begin
									if (cnt_q >= cfg.max_value_length) begin
										phase_d = PH_DONE;
										ok_d    = 1'b0;
									end else if (b == CH_PLUS) begin
										res[n] = byte_entry(CH_SPACE);
										n      = n + 2'd1;
										cnt_d  = cnt_q + 8'd1;
									end else if (b == CH_PERCENT) begin
										esc_d = ESC_PERCENT;
									end else begin
										res[n] = byte_entry(b);
										n      = n + 2'd1;
										cnt_d  = cnt_q + 8'd1;
									end
								end
								ESC_PERCENT: begin
									pend_d = b;
									esc_d  = ESC_ONE;
								end
								default: begin
									if (hi_h[4] && lo_h[4]) begin
										res[n] = byte_entry({hi_h[3:0], lo_h[3:0]});
										n      = n + 2'd1;
										cnt_d  = cnt_q + 8'd1;
										esc_d  = ESC_NONE;
									end else begin
										phase_d = PH_DONE;
										ok_d    = 1'b0;
										esc_d   = ESC_NONE;
									end
								end
							endcase
						end
						default: ;
					endcase
				end
				// end of field: flush a short escape, close the value, or restart key matching
				if (b == CH_NUL || b == CH_AMP || body.body_last) begin
					if (phase_d == PH_VALUE) begin
						if (esc_d != ESC_NONE) begin
							res[n] = byte_entry(CH_PERCENT);
							n      = n + 2'd1;
							cnt_d  = cnt_d + 8'd1;
						end
						if (esc_d == ESC_ONE && cnt_d >= cfg.max_value_length) begin
							phase_d = PH_DONE;
							ok_d    = 1'b0;
							esc_d   = ESC_NONE;
						end else begin
							if (esc_d == ESC_ONE) begin
								res[n] = byte_entry((pend_d == CH_PLUS) ? CH_SPACE : pend_d);
								n      = n + 2'd1;
								cnt_d  = cnt_d + 8'd1;
							end
							esc_d   = ESC_NONE;
							phase_d = PH_DONE;
							ok_d    = 1'b1;
						end
					end else if (phase_d != PH_DONE) begin
						phase_d = PH_MATCH;
						kpos_d  = 4'd0;
					end
				end
			end
			if (body.body_last) begin
				st.status_valid = 1'b1;
				st.status_ok    = found_d && ok_d;
				res[n]  = st;
				n       = n + 2'd1;
				phase_d = PH_MATCH;
				kpos_d  = 4'd0;
				esc_d   = ESC_NONE;
				pend_d  = 8'd0;
				cnt_d   = 8'd0;
				found_d = 1'b0;
				ok_d    = 1'b0;
				ended_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MATCH;
			kpos_q  <= 4'd0;
			esc_q   <= ESC_NONE;
			pend_q  <= 8'd0;
			cnt_q   <= 8'd0;
			found_q <= 1'b0;
			ok_q    <= 1'b0;
			ended_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			kpos_q  <= kpos_d;
			esc_q   <= esc_d;
			pend_q  <= pend_d;
			cnt_q   <= cnt_d;
			found_q <= found_d;
			ok_q    <= ok_d;
			ended_q <= ended_d;
		end
	end

	assign bundle_push  = accept && (n != 2'd0);
	assign bundle.count = n;
	assign bundle.entry = res;

endmodule

`default_nettype wire

@@ src/ffpd_queue.sv @@
// ----------------------------------------------------------------------------
// ffpd_queue
// Small first-in first-out buffer of result bundles between parser and
// output serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpd_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire ffpd_pkg::bundle_t wr_data,
	output logic                   full,
	input  wire logic              rd_en,
	output ffpd_pkg::bundle_t      rd_data,
	output logic                   empty
);
	import ffpd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/ffpd_back.sv @@
// ----------------------------------------------------------------------------
// ffpd_back
// Output serializer: walks the results of each bundle into the output
// register, marking the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ffpd_pkg::bundle_t head,
	input  wire logic              head_empty,
	output logic                   head_pop,
	output logic                   empty,
	input  wire logic              pop,
	output ffpd_pkg::result_t      result
);
	import ffpd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	result_t    out_q;
	entry_t     cur;
	logic       cur_last;
	logic       load;

	assign cur      = head.entry[idx_q];
	assign cur_last = (idx_q == head.count - 2'd1);
	// output register refills while the old word is popped
	assign load     = !head_empty && (!valid_q || pop);
	assign head_pop = load && cur_last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= {cur.out_byte, cur.byte_valid, cur.status_valid, cur.status_ok,
				cur_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= cur_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !valid_q;
	assign result = out_q;

endmodule

`default_nettype wire

@@ src/form_field_percent_decoder.sv @@
// ----------------------------------------------------------------------------
// form_field_percent_decoder
// Finds one key in a URL-encoded form body and streams its decoded value.
// ----------------------------------------------------------------------------
// Body words enter on push/full, one per cycle while full is low. Each word
// carries a byte and a last flag. Results leave on empty/pop: decoded value
// bytes, then one status word on the body's last byte; run_last marks the
// last result caused by one body word. A word may cause zero to three
// results.
// With the output side idle, the first result of a word passes through the
// bundle queue and the output register to the output ports. The parser
// takes one word per cycle while full is low; the output side gives one
// result per cycle while pop is high, so words that cause several results
// are drained at that rate through a QUEUE_DEPTH-entry bundle queue.
// When the receiver stalls the queue fills and full rises; nothing is lost.
// Reset clears the parser and queue and loads key_len 4, key_text 0,
// max_value_length 32. Registers are written through wr_en/wr_index/wr_data
// by the user, who must do so only while the block is idle; the block does not enforce it. Index 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module form_field_percent_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire ffpd_pkg::body_t   body,
	output logic                   empty,
	input  wire logic              pop,
	output ffpd_pkg::result_t      result,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [63:0]       wr_data
);
	import ffpd_pkg::*;

	cfg_t    cfg_q;
	logic    accept;
	logic    bundle_push;
	bundle_t bundle;
	bundle_t head;
	logic    head_empty;
	logic    head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_text         <= 64'd0;
			cfg_q.key_len          <= 4'd4;
			cfg_q.max_value_length <= 8'd32;
		end else if (wr_en) begin
			case (wr_index)
				REG_KEY_TEXT:         cfg_q.key_text <= wr_data;
				REG_KEY_LENGTH:       cfg_q.key_len <= wr_data[3:0];
				REG_MAX_VALUE_LENGTH: cfg_q.max_value_length <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	ffpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.body        (body),
		.cfg         (cfg_q),
		.bundle_push (bundle_push),
		.bundle      (bundle)
	);

	ffpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bundle_push),
		.wr_data (bundle),
		.full    (full),
		.rd_en   (head_pop),
		.rd_data (head),
		.empty   (head_empty)
	);

	ffpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

`ifndef SYNTHESIS
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status_valid) |-> result.run_last)
		else $error("status word not marked last");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.byte_valid != result.status_valid))
		else $error("result word is neither byte nor status, or both");

	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_push |-> (bundle.count != 2'd0))
		else $error("empty bundle queued");

	a_no_pop_empty_queue: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> !head_empty)
		else $error("bundle queue read while empty");
`endif

endmodule

`default_nettype wire

@@ dv/tb_form_field_percent_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_form_field_percent_decoder
// Self-checking bench for the form field percent decoder. Form bodies are
// built around the configured key, with decoded values, escapes, broken
// escapes, early zero bytes and noise. A scoreboard follows the parser word
// by word and checks every result word in order. Both handshakes idle at
// random except in the last phases, and the key and length limit change between phases.
// ----------------------------------------------------------------------------

class decode_scoreboard;
	typedef enum logic [1:0] {PH_KEY, PH_SKIP, PH_VALUE, PH_DONE} parse_phase_e;
	typedef enum logic [1:0] {ESC_NONE, ESC_PERCENT, ESC_CHAR} escape_e;

	logic [63:0] key_text;
	logic [3:0]  key_len;
	logic [7:0]  max_value_length;

	parse_phase_e parse_phase;
	logic [3:0]   key_pos;
	escape_e      esc;
	logic [7:0]   pending_char;
	logic [7:0]   out_count;
	bit           found;
	bit           value_ok;
	bit           ended;

	ffpd_pkg::result_t expected_words[$];
	ffpd_pkg::entry_t  step_words[$];
	int                errors;

	function new();
		key_text = '0;
		key_len = 4'd4;
		max_value_length = 8'd32;
		errors = 0;
		clear_parser();
	endfunction

	function void clear_parser();
		parse_phase = PH_KEY;
		key_pos = '0;
		esc = ESC_NONE;
		pending_char = '0;
		out_count = '0;
		found = 1'b0;
		value_ok = 1'b0;
		ended = 1'b0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [63:0] val);
		case (idx)
			ffpd_pkg::REG_KEY_TEXT: key_text = val;
			ffpd_pkg::REG_KEY_LENGTH: key_len = val[3:0];
			ffpd_pkg::REG_MAX_VALUE_LENGTH: max_value_length = val[7:0];
			default: ;
		endcase
	endfunction

	// longer keys are cut to what the matcher compares
	function logic [3:0] key_span();
		return (key_len > ffpd_pkg::MAX_KEY_LENGTH) ? ffpd_pkg::MAX_KEY_LENGTH : key_len;
	endfunction

	function logic [7:0] key_char(int unsigned i);
		return key_text[8*i +: 8];
	endfunction

	function void add_entry(logic [7:0] b, bit bv, bit sv, bit ok);
		ffpd_pkg::entry_t e;
		e.out_byte = b;
		e.byte_valid = bv;
		e.status_valid = sv;
		e.status_ok = ok;
		step_words.push_back(e);
	endfunction

	function void emit(logic [7:0] b);
		add_entry(b, 1'b1, 1'b0, 1'b0);
		out_count++;
	endfunction

	function void fail_value();
		parse_phase = PH_DONE;
		value_ok = 1'b0;
		esc = ESC_NONE;
	endfunction

	function bit hex_nibble(logic [7:0] c, output logic [3:0] v);
		v = '0;
		if (c >= "0" && c <= "9") begin
			v = c[3:0];
			return 1'b1;
		end
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
			v = c[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// a dangling escape at the end of the value goes out literally
	function void finish_field();
		if (parse_phase == PH_VALUE) begin
			if (esc != ESC_NONE) begin
				emit(ffpd_pkg::CH_PERCENT);
				if (esc == ESC_CHAR) begin
					if (out_count >= max_value_length) begin
						fail_value();
						return;
					end
					emit((pending_char == ffpd_pkg::CH_PLUS) ? ffpd_pkg::CH_SPACE : pending_char);
				end
			end
			esc = ESC_NONE;
			parse_phase = PH_DONE;
			value_ok = 1'b1;
		end else if (parse_phase != PH_DONE) begin
			parse_phase = PH_KEY;
			key_pos = '0;
		end
	endfunction

	function void value_byte(logic [7:0] b);
		logic [3:0] hi;
		logic [3:0] lo;
		case (esc)
			ESC_NONE: begin
				if (out_count >= max_value_length)
					fail_value();
				else if (b == ffpd_pkg::CH_PLUS)
					emit(ffpd_pkg::CH_SPACE);
				else if (b == ffpd_pkg::CH_PERCENT)
					esc = ESC_PERCENT;
				else
					emit(b);
			end
			ESC_PERCENT: begin
				pending_char = b;
				esc = ESC_CHAR;
			end
			default: begin
				if (hex_nibble(pending_char, hi) && hex_nibble(b, lo)) begin
					emit({hi, lo});
					esc = ESC_NONE;
				end else begin
					fail_value();
				end
			end
		endcase
	endfunction

	function void note_body(ffpd_pkg::body_t w);
		ffpd_pkg::result_t r;
		step_words.delete();
		if (!ended) begin
			if (w.body_byte == ffpd_pkg::CH_NUL) begin
				finish_field();
				ended = 1'b1;
			end else if (w.body_byte == ffpd_pkg::CH_AMP) begin
				finish_field();
			end else if (parse_phase == PH_KEY) begin
				if (key_pos < key_span()) begin
					if (w.body_byte == key_char(key_pos))
						key_pos++;
					else
						parse_phase = PH_SKIP;
				end else if (w.body_byte == ffpd_pkg::CH_EQ) begin
					found = 1'b1;
					parse_phase = PH_VALUE;
					out_count = '0;
					esc = ESC_NONE;
				end else begin
					parse_phase = PH_SKIP;
				end
			end else if (parse_phase == PH_VALUE) begin
				value_byte(w.body_byte);
			end
		end
		if (w.body_last) begin
			if (!ended)
				finish_field();
			add_entry(8'h00, 1'b0, 1'b1, found && value_ok);
			clear_parser();
		end
		foreach (step_words[i]) begin
			r.out_byte = step_words[i].out_byte;
			r.byte_valid = step_words[i].byte_valid;
			r.status_valid = step_words[i].status_valid;
			r.status_ok = step_words[i].status_ok;
			r.run_last = (i == step_words.size() - 1);
			expected_words.push_back(r);
		end
	endfunction

	function void check_result(ffpd_pkg::result_t got);
		ffpd_pkg::result_t want;
		if (expected_words.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: result word with nothing expected: byte %h bv %b sv %b ok %b last %b",
					$realtime, got.out_byte, got.byte_valid, got.status_valid,
					got.status_ok, got.run_last);
			return;
		end
		want = expected_words.pop_front();
		if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
				got.status_valid !== want.status_valid || got.status_ok !== want.status_ok ||
				got.run_last !== want.run_last) begin
			errors++;
			if (errors <= 10)
				$display("%0t: result mismatch: byte %h/%h bv %b/%b sv %b/%b ok %b/%b last %b/%b",
					$realtime, got.out_byte, want.out_byte, got.byte_valid, want.byte_valid,
					got.status_valid, want.status_valid, got.status_ok, want.status_ok,
					got.run_last, want.run_last);
		end
	endfunction

	function int outstanding();
		return expected_words.size();
	endfunction

	function void close_out();
		if (expected_words.size() > 0) begin
			$display("%0d expected result words never came", expected_words.size());
			errors += expected_words.size();
		end
	endfunction
endclass

module tb_form_field_percent_decoder;
	import ffpd_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES = 6;
	localparam int WORDS_PER_PHASE = 20;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	body_t       body;
	logic        empty;
	logic        pop;
	result_t     result;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [63:0] wr_data;

	int         send_idle;
	int         recv_idle;
	int         idle_cycles;
	int         live_words;
	logic [7:0] form_q[$];

	decode_scoreboard sb = new();

	form_field_percent_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.body(body),
		.empty(empty),
		.pop(pop),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(result);
			pop <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// any accepted word on either side counts as progress
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_form_field_percent_decoder: done, errors");
				$finish;
			end
		end
	end

	task automatic send_word(input body_t w);
		push <= 1'b1;
		body <= w;
		do @(posedge clk); while (full);
		sb.note_body(w);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_form();
		body_t w;
		foreach (form_q[i]) begin
			w.body_byte = form_q[i];
			w.body_last = (i == form_q.size() - 1);
			send_word(w);
		end
		form_q.delete();
	endtask

	task automatic drain_all();
		push <= 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [63:0] key, input logic [3:0] len,
			input logic [7:0] max_len, input bit poke_unused);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		wr_en <= 1'b1;
		if (poke_unused) begin
			wr_index <= REG_UNUSED;
			wr_data <= junk;
			@(posedge clk);
			sb.write_reg(REG_UNUSED, junk);
		end
		wr_index <= REG_KEY_TEXT;
		wr_data <= key;
		@(posedge clk);
		sb.write_reg(REG_KEY_TEXT, key);
		wr_index <= REG_KEY_LENGTH;
		wr_data <= {60'd0, len};
		@(posedge clk);
		sb.write_reg(REG_KEY_LENGTH, {60'd0, len});
		wr_index <= REG_MAX_VALUE_LENGTH;
		wr_data <= {56'd0, max_len};
		@(posedge clk);
		sb.write_reg(REG_MAX_VALUE_LENGTH, {56'd0, max_len});
		wr_en <= 1'b0;
	endtask

	function automatic void load_text(string s);
		foreach (s[i])
			form_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(8'h21, 8'h7e));
		if (c == CH_AMP)
			c = "x";
		return c;
	endfunction

	function automatic logic [63:0] letter_key();
		logic [63:0] k;
		for (int i = 0; i < 8; i++)
			k[8*i +: 8] = 8'($urandom_range("a", "z"));
		return k;
	endfunction

	function automatic void add_value();
		int r;
		repeat ($urandom_range(0, 7)) begin
			r = $urandom_range(0, 19);
			if (r < 10) begin
				form_q.push_back(plain_char());
			end else if (r < 13) begin
				form_q.push_back(CH_PLUS);
			end else if (r < 17) begin
				form_q.push_back(CH_PERCENT);
				form_q.push_back(hex_char());
				form_q.push_back(hex_char());
			end else if (r == 17) begin
				form_q.push_back(CH_PERCENT);
				form_q.push_back(hex_char());
				form_q.push_back("g");
			end else if (r == 18) begin
				form_q.push_back(CH_PERCENT);
				form_q.push_back("Z");
				form_q.push_back(hex_char());
			end else begin
				form_q.push_back(8'($urandom_range(8'h80, 8'hff)));
			end
		end
		// escape cut short by the end of the field
		r = $urandom_range(0, 9);
		if (r == 0) begin
			form_q.push_back(CH_PERCENT);
		end else if (r == 1) begin
			form_q.push_back(CH_PERCENT);
			form_q.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : plain_char());
		end
	endfunction

	function automatic void build_form();
		int fields;
		int pick;
		int span;
		int cut;
		form_q.delete();
		span = sb.key_span();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				form_q.push_back(8'($urandom_range(0, 255)));
			live_words = form_q.size();
			return;
		end
		fields = $urandom_range(1, 3);
		for (int f = 0; f < fields; f++) begin
			if (f > 0)
				form_q.push_back(CH_AMP);
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				for (int i = 0; i < span; i++)
					form_q.push_back(sb.key_char(i));
				form_q.push_back(CH_EQ);
				add_value();
			end else if (pick < 8) begin
				// near miss: part of the key, then something else
				cut = $urandom_range(0, span);
				for (int i = 0; i < cut; i++)
					form_q.push_back(sb.key_char(i));
				form_q.push_back(plain_char());
				if ($urandom_range(0, 1) == 1) begin
					form_q.push_back(CH_EQ);
					add_value();
				end
			end else begin
				repeat ($urandom_range(1, 4))
					form_q.push_back(8'($urandom_range("a", "z")));
				form_q.push_back(CH_EQ);
				add_value();
			end
		end
		live_words = form_q.size();
		// zero byte ends the body early, the rest is ignored
		if ($urandom_range(0, 14) == 0) begin
			cut = $urandom_range(0, form_q.size());
			form_q.insert(cut, CH_NUL);
			live_words = cut + 1;
			repeat ($urandom_range(0, 3))
				form_q.push_back(plain_char());
		end
	endfunction

	initial begin
		int sent;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		body = '0;
		wr_en = 1'b0;
		wr_index = REG_KEY_TEXT;
		wr_data = '0;
		idle_cycles = 0;
		send_idle = 15;
		recv_idle = 84;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key "ab", at most three value bytes
		set_config(64'h6261, 4'd2, 8'd3, 1'b0);
		load_text("ab=%4A+%z");
		send_form();
		load_text("ab=1&ab=2");
		form_q.push_back(CH_NUL);
		form_q.push_back(8'hff);
		send_form();
		load_text("ab=%G1");
		send_form();
		drain_all();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			send_idle = (p < 2) ? 15 : (p < 4) ? 84 : 0;
			recv_idle = (p < 2) ? 84 : (p < 4) ? 15 : 0;
			case (p)
				0: set_config(64'h7265_7375, 4'd4, 8'd255, 1'b0);
				1: set_config(letter_key(), 4'd15, 8'd0, 1'b0);
				2: set_config(64'hffff_ffff_ffff_ffff, 4'd0, 8'd5, 1'b1);
				3: set_config({$urandom, $urandom}, 4'd1, 8'd8, 1'b0);
				4: set_config(64'h6469, 4'd2, 8'd3, 1'b0);
				default: set_config(letter_key(), 4'd8, 8'd12, 1'b0);
			endcase
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				build_form();
				sent += live_words;
				send_form();
				if ($urandom_range(0, 7) == 0)
					drain_all();
			end
			drain_all();
		end

		sb.close_out();
		if (sb.errors == 0)
			$display("tb_form_field_percent_decoder: done, clean");
		else
			$display("tb_form_field_percent_decoder: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
src/ffpd_pkg.sv
src/ffpd_front.sv
src/ffpd_queue.sv
src/ffpd_back.sv
src/form_field_percent_decoder.sv
dv/tb_form_field_percent_decoder.sv
